>>> rtl/core/das_pkg.sv
// shared types and constants for the dataflow actor scheduler
// no dependencies; imported by das_ctrl, das_datapath and the top level
package das_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ACTOR_W         = 6;
    localparam int COUNT_W         = 7;
    localparam int NUM_ACTORS      = 64;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_DELIVER = 2'd1,
        OP_PULL    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        REG_LOCAL_ACTOR_COUNT = 1'b0,
        REG_RING_TOPOLOGY     = 1'b1
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [ACTOR_W-1:0] actor_id;
        logic               owned_here;
    } sched_in_t;

    typedef struct packed {
        logic               valid_res;
        logic [ACTOR_W-1:0] actor_out;
        logic               from_round_robin;
        logic               forwarded;
    } sched_out_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_t;

endpackage

>>> rtl/core/das_ctrl.sv
// controller state machine of the actor scheduler
// depends on das_pkg; drives capture and execute commands to das_datapath
module das_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output das_pkg::ctl_t ctl
);
    import das_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        ctl.capture = 1'b0;
        ctl.execute = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.execute = 1'b1;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");
    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted beat did not enter execute");
    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute not followed by result strobe");
`endif

endmodule

>>> rtl/core/das_datapath.sv
// datapath of the actor scheduler: ready fifo memory, flag bits, round robin
// depends on das_pkg; commanded by das_ctrl
module das_datapath #(
    parameter int QUEUE_DEPTH = das_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  das_pkg::ctl_t                ctl,
    input  das_pkg::sched_in_t           item,
    input  logic                         wr_en,
    input  das_pkg::reg_idx_t            wr_index,
    input  logic [das_pkg::COUNT_W-1:0]  wr_data,
    output das_pkg::sched_out_t          result
);
    import das_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [ACTOR_W-1:0] mem [QUEUE_DEPTH];
    logic [ACTOR_W-1:0] rd_data_reg;
    sched_in_t          in_reg;
    sched_out_t         res_reg;
    sched_out_t         res_next;

    logic [IDX_W-1:0]   head_idx_reg, head_idx_next;
    logic               head_wrap_reg, head_wrap_next;
    logic [IDX_W-1:0]   tail_idx_reg, tail_idx_next;
    logic               tail_wrap_reg, tail_wrap_next;
    logic [ACTOR_W-1:0] rr_slot_reg, rr_slot_next;
    logic [NUM_ACTORS-1:0] queued_reg, queued_next;
    logic [NUM_ACTORS-1:0] waiting_reg, waiting_next;
    logic [COUNT_W-1:0] count_reg;
    logic               ring_reg;

    logic               empty;
    logic               full;
    logic               push;
    logic               pop;
    logic [COUNT_W-1:0] cnt;
    logic [ACTOR_W-1:0] slot;
    logic [COUNT_W-1:0] slot_inc;

    assign empty = (head_idx_reg == tail_idx_reg) && (head_wrap_reg == tail_wrap_reg);
    assign full  = (head_idx_reg == tail_idx_reg) && (head_wrap_reg != tail_wrap_reg);

    assign cnt      = (count_reg > COUNT_W'(NUM_ACTORS)) ? COUNT_W'(NUM_ACTORS) : count_reg;
    assign slot     = ({1'b0, rr_slot_reg} < cnt) ? rr_slot_reg : '0;
    assign slot_inc = {1'b0, slot} + COUNT_W'(1);

    always_comb
    begin
        res_next     = '0;
        push         = 1'b0;
        pop          = 1'b0;
        rr_slot_next = rr_slot_reg;
        queued_next  = queued_reg;
        waiting_next = waiting_reg;
        if (ctl.execute)
        begin
            case (op_t'(in_reg.opcode))
                OP_ADD:
                begin
                    if (!queued_reg[in_reg.actor_id])
                    begin
                        if (in_reg.owned_here)
                        begin
                            if (!full)
                            begin
                                push                         = 1'b1;
                                queued_next[in_reg.actor_id] = 1'b1;
                            end
                        end
                        else if (!waiting_reg[in_reg.actor_id])
                        begin
                            waiting_next[in_reg.actor_id] = 1'b1;
                            res_next.valid_res            = 1'b1;
                            res_next.actor_out            = in_reg.actor_id;
                            res_next.forwarded            = 1'b1;
                        end
                    end
                end
                OP_DELIVER:
                begin
                    if (in_reg.owned_here || !ring_reg)
                    begin
                        if (!full)
                        begin
                            push                         = 1'b1;
                            queued_next[in_reg.actor_id] = 1'b1;
                        end
                        waiting_next[in_reg.actor_id] = 1'b0;
                    end
                    else
                    begin
                        res_next.valid_res = 1'b1;
                        res_next.actor_out = in_reg.actor_id;
                        res_next.forwarded = 1'b1;
                    end
                end
                OP_PULL:
                begin
                    if (!empty)
                    begin
                        pop                       = 1'b1;
                        queued_next[rd_data_reg]  = 1'b0;
                        res_next.valid_res        = 1'b1;
                        res_next.actor_out        = rd_data_reg;
                    end
                    else
                    begin
                        res_next.from_round_robin = 1'b1;
                        if (cnt != '0)
                        begin
                            res_next.valid_res = 1'b1;
                            res_next.actor_out = slot;
                            rr_slot_next       = (slot_inc >= cnt) ? '0
                                                                   : slot_inc[ACTOR_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        head_idx_next  = head_idx_reg;
        head_wrap_next = head_wrap_reg;
        tail_idx_next  = tail_idx_reg;
        tail_wrap_next = tail_wrap_reg;
        if (pop)
        begin
            if (head_idx_reg == LAST_IDX)
            begin
                head_idx_next  = '0;
                head_wrap_next = ~head_wrap_reg;
            end
            else
            begin
                head_idx_next = head_idx_reg + IDX_W'(1);
            end
        end
        if (push)
        begin
            if (tail_idx_reg == LAST_IDX)
            begin
                tail_idx_next  = '0;
                tail_wrap_next = ~tail_wrap_reg;
            end
            else
            begin
                tail_idx_next = tail_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx_reg  <= '0;
            head_wrap_reg <= 1'b0;
            tail_idx_reg  <= '0;
            tail_wrap_reg <= 1'b0;
            rr_slot_reg   <= '0;
            queued_reg    <= '0;
            waiting_reg   <= '0;
            count_reg     <= '0;
            ring_reg      <= 1'b1;
        end
        else
        begin
            head_idx_reg  <= head_idx_next;
            head_wrap_reg <= head_wrap_next;
            tail_idx_reg  <= tail_idx_next;
            tail_wrap_reg <= tail_wrap_next;
            rr_slot_reg   <= rr_slot_next;
            queued_reg    <= queued_next;
            waiting_reg   <= waiting_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_LOCAL_ACTOR_COUNT: count_reg <= wr_data;
                    REG_RING_TOPOLOGY:     ring_reg  <= wr_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // fifo storage, head entry read while the beat is captured
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_idx_reg] <= in_reg.actor_id;
        end
        if (ctl.capture)
        begin
            rd_data_reg <= mem[head_idx_reg];
            in_reg      <= item;
        end
        if (ctl.execute)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

`ifndef ASSERT_OFF
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_idx_reg <= LAST_IDX) && (tail_idx_reg <= LAST_IDX))
        else $error("fifo pointer out of range");
    a_pop_clears_queued: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !queued_reg[$past(rd_data_reg)])
        else $error("popped actor still marked queued");
    a_fwd_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_next.forwarded |-> (res_next.valid_res && !res_next.from_round_robin))
        else $error("forwarded result malformed");
    a_rr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.execute && res_next.from_round_robin && (cnt != '0))
        |=> ({1'b0, rr_slot_reg} < $past(cnt)))
        else $error("round robin slot out of range");
`endif

endmodule

>>> rtl/core/dataflow_actor_scheduler_top.sv
// top level of the dataflow actor scheduler
// depends on das_pkg, das_ctrl and das_datapath
//
//  channel   handshake           payload                      dir
//  command   start / busy        item (sched_in_t)            in
//  result    done strobe         result (sched_out_t)         out
//  config    wr_en               wr_index, wr_data            in
//
//  a beat is taken when start is high and busy is low; busy is high for the
//  following execute cycle, and done strobes in the cycle after that with the result
//  each beat is a capture step with fifo head read, then an execute step on the
//  fifo memory port and flag bits; the next beat may start while done is high
//  asynchronous active-low reset clears pointers and flags, no clearing pass
//  the receiver cannot stall; result is valid only in the done cycle
module dataflow_actor_scheduler_top #(
    parameter int QUEUE_DEPTH = das_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  das_pkg::sched_in_t           item,
    output logic                         done,
    output das_pkg::sched_out_t          result,
    input  logic                         wr_en,
    input  das_pkg::reg_idx_t            wr_index,
    input  logic [das_pkg::COUNT_W-1:0]  wr_data
);
    import das_pkg::*;

    ctl_t ctl;

    das_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    das_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .item     (item),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .result   (result)
    );

endmodule
